### rtl/core/res_pkg.sv
// Shared types and constants for the record exchange sorter.
// Holds the record layout, store sizing, controller states and the command and status structs.
// No dependencies.
package res_pkg;

    localparam int unsigned MAX_RECORDS = 32;
    localparam int unsigned CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int unsigned ADDR_W      = $clog2(MAX_RECORDS);
    localparam int unsigned KEY_W       = 2;
    localparam int unsigned TAG_W       = 16;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_HOLD,
        ST_SCAN,
        ST_WB,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        WS_LOAD,
        WS_J,
        WS_I
    } t_wr_sel;

    typedef enum logic {
        RS_I,
        RS_J
    } t_rd_sel;

    typedef struct packed {
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cnt_add;
        logic    cnt_clr;
        logic    i_clr;
        logic    i_inc;
        logic    j_load;
        logic    j_inc;
        logic    hold_ld;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic has_prev;
        logic swap;
        logic j_last;
        logic i_last;
        logic emit_last;
    } t_stat;

endpackage

### rtl/core/res_if.sv
// Valid/ready channel interfaces for the record exchange sorter.
// Depends on res_pkg for field widths.
interface res_in_if;
    import res_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] degree;
    logic [TAG_W-1:0] tag;
    logic             is_last;

    modport source (output valid, output degree, output tag, output is_last, input ready);
    modport sink (input valid, input degree, input tag, input is_last, output ready);
endinterface

interface res_out_if;
    import res_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] degree_res;
    logic [TAG_W-1:0] tag_res;
    logic             last_out;
    logic             overflow;

    modport source (output valid, output degree_res, output tag_res, output last_out,
                    output overflow, input ready);
    modport sink (input valid, input degree_res, input tag_res, input last_out,
                  input overflow, output ready);
endinterface

### rtl/core/res_datapath.sv
// Datapath of the record exchange sorter: record store, indices, hold and read registers.
// Driven by res_ctrl through a command struct; depends on res_pkg.
module res_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  res_pkg::t_cmd           i_cmd,
    input  logic [res_pkg::KEY_W-1:0] i_degree,
    input  logic [res_pkg::TAG_W-1:0] i_tag,
    output res_pkg::t_stat          o_stat,
    output logic [res_pkg::KEY_W-1:0] o_degree_res,
    output logic [res_pkg::TAG_W-1:0] o_tag_res,
    output logic                    o_overflow
);
    import res_pkg::*;

    t_rec              mem [MAX_RECORDS];
    t_rec              r_rdata;
    t_rec              r_hold;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_ovf;
    logic              n_ovf;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  n_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  n_j;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    t_rec              wr_data;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end else if (i_cmd.cnt_add) begin
            if (o_stat.full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_i = r_i;
        if (i_cmd.i_clr) begin
            n_i = '0;
        end else if (i_cmd.i_inc) begin
            n_i = r_i + CNT_W'(1);
        end
        n_j = r_j;
        if (i_cmd.j_load) begin
            n_j = r_i + CNT_W'(1);
        end else if (i_cmd.j_inc) begin
            n_j = r_j + CNT_W'(1);
        end
    end

    always_comb begin
        rd_addr = (i_cmd.rd_sel == RS_I) ? n_i[ADDR_W-1:0] : n_j[ADDR_W-1:0];
        case (i_cmd.wr_sel)
            WS_LOAD: wr_addr = r_count[ADDR_W-1:0];
            WS_J:    wr_addr = r_j[ADDR_W-1:0];
            WS_I:    wr_addr = r_i[ADDR_W-1:0];
            default: wr_addr = r_i[ADDR_W-1:0];
        endcase
        wr_data = (i_cmd.wr_sel == WS_LOAD) ? t_rec'{key: i_degree, tag: i_tag} : r_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (i_cmd.hold_ld) begin
            r_hold <= r_rdata;
        end
    end

    always_comb begin
        o_stat.full      = (r_count == CNT_W'(MAX_RECORDS));
        o_stat.has_prev  = (r_count != '0);
        o_stat.swap      = (r_hold.key > r_rdata.key);
        o_stat.j_last    = (r_j == r_count - CNT_W'(1));
        o_stat.i_last    = (r_i + CNT_W'(2) == r_count);
        o_stat.emit_last = (r_i == r_count - CNT_W'(1));
    end

    assign o_degree_res = r_rdata.key;
    assign o_tag_res    = r_rdata.tag;
    assign o_overflow   = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds store capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_W'(MAX_RECORDS))
        else $error("overflow flagged while the store has room");

    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.rd_sel == RS_J) |-> n_j < r_count)
        else $error("scan read beyond the stored records");

    a_read_i_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.rd_sel == RS_I && !i_cmd.cnt_clr) |-> n_i < r_count)
        else $error("read of an entry that was never loaded");

endmodule

### rtl/core/res_ctrl.sv
// Controller state machine of the record exchange sorter: load, sort passes and emission.
// Issues commands to res_datapath from its status; depends on res_pkg.
module res_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_is_last,
    input  logic           i_out_ready,
    input  res_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output res_pkg::t_cmd  o_cmd
);
    import res_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_is_last) begin
                    n_state = i_stat.has_prev ? ST_RD_I : ST_EMIT_RD;
                end
            end
            ST_RD_I:    n_state = ST_HOLD;
            ST_HOLD:    n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_stat.j_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB:      n_state = i_stat.i_last ? ST_EMIT_RD : ST_RD_I;
            ST_EMIT_RD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_out_ready && i_stat.emit_last) begin
                    n_state = ST_LOAD;
                end
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.wr_sel = WS_LOAD;
        o_cmd.rd_sel = RS_I;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.wr_en   = i_in_valid && !i_stat.full;
                o_cmd.wr_sel  = WS_LOAD;
                o_cmd.cnt_add = i_in_valid;
                o_cmd.i_clr   = i_in_valid && i_is_last;
            end
            ST_RD_I: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_I;
            end
            ST_HOLD: begin
                o_cmd.hold_ld = 1'b1;
                o_cmd.j_load  = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RS_J;
            end
            ST_SCAN: begin
                o_cmd.wr_en   = i_stat.swap;
                o_cmd.wr_sel  = WS_J;
                o_cmd.hold_ld = i_stat.swap;
                o_cmd.j_inc   = !i_stat.j_last;
                o_cmd.rd_en   = !i_stat.j_last;
                o_cmd.rd_sel  = RS_J;
            end
            ST_WB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_I;
                o_cmd.i_clr  = i_stat.i_last;
                o_cmd.i_inc  = !i_stat.i_last;
            end
            ST_EMIT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_I;
            end
            ST_EMIT: begin
                o_out_valid   = 1'b1;
                o_cmd.cnt_clr = i_out_ready && i_stat.emit_last;
                o_cmd.i_inc   = i_out_ready && !i_stat.emit_last;
                o_cmd.rd_en   = i_out_ready && !i_stat.emit_last;
                o_cmd.rd_sel  = RS_I;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("loading and emitting at the same time");

    a_emit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_out_ready && i_stat.emit_last) |=> o_in_ready)
        else $error("controller did not return to loading after the final result");

    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_is_last) |=> !o_in_ready)
        else $error("final record did not start the sort");

endmodule

### rtl/core/record_exchange_sort.sv
// Top level of the record exchange sorter; joins res_ctrl and res_datapath to the channels.
// Depends on res_pkg and the interfaces in res_if.
//
// Records are taken one per cycle and stored in arrival order, up to 32 of them; any further
// records are dropped and every result of that set carries the overflow flag. The record marked
// last starts the sort, during which no input is taken. The sort is paced by the single read
// port of the record store that every compare goes through; emission then fetches the first
// record in ST_EMIT_RD and gives one result per cycle after that while the sink is ready.
// Equal keys leave in the order the exchange pass gives, which is not stable, and last_out
// marks the final result.
module record_exchange_sort (
    input  logic      i_clk,
    input  logic      i_rst_n,
    res_in_if.sink    i_in,
    res_out_if.source o_out
);
    import res_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    res_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_is_last   (i_in.is_last),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    res_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_degree     (i_in.degree),
        .i_tag        (i_in.tag),
        .o_stat       (stat),
        .o_degree_res (o_out.degree_res),
        .o_tag_res    (o_out.tag_res),
        .o_overflow   (o_out.overflow)
    );

    assign o_out.last_out = stat.emit_last;

endmodule
